// ===== design/led_efr_pkg.sv =====
// Shared types, constants and constant tables of the LED effect frame renderer.
`timescale 1ns / 1ps

package led_efr_pkg;

    // PWM resolution of the duty word
    localparam int DUTY_BITS = 8;

    localparam int TICK_W   = 32;
    localparam int SPEED_W  = 10;
    localparam int TIME_W   = 26;   // (2^32 - 1) / 100 fits in 26 bits
    localparam int LEVEL_W  = 8;
    localparam int PWM_W    = 9;
    localparam int CFG_DATA_W = 10;

    localparam int LEVEL_MAX    = 255;
    localparam int DUTY_TOP_INT = (1 << DUTY_BITS) - 1;

    localparam logic [DUTY_BITS-1:0] DUTY_TOP  = '1;
    localparam logic [DUTY_BITS:0]   DUTY_FULL = {1'b1, {DUTY_BITS{1'b0}}};

    // Reciprocals floor(2^S / D); S is the dividend width, so the estimate
    // is the true quotient or one below it.
    localparam logic [25:0] K_TIME = 26'd42949672;  // 2^32 / 100
    localparam logic [21:0] K_Q25  = 22'd2684354;   // 2^26 / 25
    localparam logic [21:0] K_Q180 = 22'd372827;    // 2^26 / 180
    localparam logic [21:0] K_Q300 = 22'd223696;    // 2^26 / 300

    localparam int RIPPLE_PERIOD = 180;
    localparam int RIPPLE_HALF   = RIPPLE_PERIOD / 2;
    localparam int PULSE_PERIOD  = 100;
    localparam int PULSE_HALF    = PULSE_PERIOD / 2;

    typedef enum logic [2:0] {
        EFF_OFF    = 3'd0,
        EFF_SOLID  = 3'd1,
        EFF_RIPPLE = 3'd2,
        EFF_PULSE  = 3'd3,
        EFF_BLINK  = 3'd4,
        EFF_CYCLE  = 3'd5
    } effect_t;

    typedef enum logic [2:0] {
        REG_EFFECT_MODE = 3'd0,
        REG_RED         = 3'd1,
        REG_GREEN       = 3'd2,
        REG_BLUE        = 3'd3,
        REG_BRIGHTNESS  = 3'd4,
        REG_SPEED       = 3'd5,
        REG_ACTIVE_LOW  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0]         effect_mode;
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic [LEVEL_W-1:0] brightness;
        logic [SPEED_W-1:0] speed_percent;
        logic               active_low;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] tri_ripple;
        logic [LEVEL_W-1:0] tri_pulse;
        logic               blink_odd;
        logic               cycle_dark;
    } phase_t;

    typedef logic [LEVEL_W-1:0]   tri_ripple_tab_t [RIPPLE_PERIOD];
    typedef logic [LEVEL_W-1:0]   tri_pulse_tab_t  [PULSE_PERIOD];
    typedef logic [DUTY_BITS-1:0] duty_tab_t       [LEVEL_MAX+1];

    function automatic tri_ripple_tab_t make_tri_ripple();
        tri_ripple_tab_t tab;
        for (int i = 0; i < RIPPLE_PERIOD; i++)
        begin
            if (i < RIPPLE_HALF)
                tab[i] = LEVEL_W'(i * LEVEL_MAX / RIPPLE_HALF);
            else
                tab[i] = LEVEL_W'((RIPPLE_PERIOD - i) * LEVEL_MAX / RIPPLE_HALF);
        end
        return tab;
    endfunction

    function automatic tri_pulse_tab_t make_tri_pulse();
        tri_pulse_tab_t tab;
        for (int i = 0; i < PULSE_PERIOD; i++)
        begin
            if (i < PULSE_HALF)
                tab[i] = LEVEL_W'(i * LEVEL_MAX / PULSE_HALF);
            else
                tab[i] = LEVEL_W'((PULSE_PERIOD - i) * LEVEL_MAX / PULSE_HALF);
        end
        return tab;
    endfunction

    function automatic duty_tab_t make_duty();
        duty_tab_t tab;
        for (int i = 0; i <= LEVEL_MAX; i++)
        begin
            tab[i] = DUTY_BITS'(i * DUTY_TOP_INT / LEVEL_MAX);
        end
        return tab;
    endfunction

    localparam tri_ripple_tab_t TRI_RIPPLE = make_tri_ripple();
    localparam tri_pulse_tab_t  TRI_PULSE  = make_tri_pulse();
    localparam duty_tab_t       DUTY_TAB   = make_duty();

endpackage

// ===== design/led_efr_tick.sv =====
// Effect time: tick times speed (wrapping), then divided by 100 over three stages.
`timescale 1ns / 1ps

module led_efr_tick
    import led_efr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SPEED_W-1:0] speed_percent,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TICK_W-1:0] in_tick,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TIME_W-1:0] out_time
);

    localparam logic [7:0] TIME_DIV = 8'd100;

    logic [2:0] vld_reg;
    logic [3:0] rdy;

    logic [TICK_W-1:0] prod_reg, prod_next;
    logic [TICK_W-1:0] prod1_reg;
    logic [TIME_W-1:0] est_reg, est_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [57:0]       recip_mul;
    logic [7:0]        rem;

    always_comb
    begin
        rdy[3] = out_ready;
        for (int i = 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[2];
    assign out_time  = time_reg;

    // wraps modulo 2^32
    assign prod_next = in_tick * TICK_W'(speed_percent);

    assign recip_mul = 58'(prod_reg) * 58'(K_TIME);
    assign est_next  = recip_mul[57:32];

    // remainder is below 200, so the low byte carries it exactly
    assign rem       = prod1_reg[7:0] - 8'(est_reg[7:0] * TIME_DIV);
    assign time_next = est_reg + TIME_W'(rem >= TIME_DIV);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= in_valid;
            for (int i = 1; i < 3; i++)
            begin
                if (rdy[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
            prod_reg <= prod_next;
        if (rdy[1])
        begin
            prod1_reg <= prod_reg;
            est_reg   <= est_next;
        end
        if (rdy[2])
            time_reg <= time_next;
    end

endmodule

// ===== design/led_efr_phase.sv =====
// Waveform phases of the effect time and triangle lookups, four stages.
`timescale 1ns / 1ps

module led_efr_phase
    import led_efr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TIME_W-1:0] in_time,
    output logic              out_valid,
    input  logic              out_ready,
    output phase_t            out_phase
);

    localparam logic [5:0] DIV_BLINK   = 6'd25;
    localparam logic [8:0] DIV_RIPPLE  = 9'd180;
    localparam logic [9:0] DIV_CYCLE   = 10'd300;
    localparam logic [9:0] CYCLE_STEP  = 10'd50;
    localparam logic [6:0] BLINK_STEP  = 7'd25;

    logic [3:0] vld_reg;
    logic [4:0] rdy;

    // stage 0: quotient estimates
    logic [47:0]       mul25, mul180, mul300;
    logic [TIME_W-1:0] time_reg;
    logic [21:0]       e25_reg, e180_reg, e300_reg;

    // stage 1: corrected remainders
    logic [5:0] r25_raw;
    logic [8:0] r180_raw;
    logic [9:0] r300_raw, r300_fix;
    logic       r25_hi;
    logic [4:0] r25_reg, r25_next;
    logic [1:0] q25_reg, q25_next;
    logic [7:0] r180_reg, r180_next;
    logic       dark_reg, dark_next;

    // stage 2: phase within the pulse period
    logic [6:0] r100_reg, r100_next;
    logic [7:0] r180b_reg;
    logic       odd_reg;
    logic       dark2_reg;

    // stage 3: table outputs
    phase_t phase_reg, phase_next;

    always_comb
    begin
        rdy[4] = out_ready;
        for (int i = 3; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[3];
    assign out_phase = phase_reg;

    assign mul25  = 48'(in_time) * 48'(K_Q25);
    assign mul180 = 48'(in_time) * 48'(K_Q180);
    assign mul300 = 48'(in_time) * 48'(K_Q300);

    // each raw remainder is below twice its divisor and fits its low bits
    assign r25_raw  = time_reg[5:0] - 6'(e25_reg[5:0] * DIV_BLINK);
    assign r180_raw = time_reg[8:0] - 9'(e180_reg[8:0] * DIV_RIPPLE);
    assign r300_raw = time_reg[9:0] - 10'(e300_reg[9:0] * DIV_CYCLE);
    assign r25_hi   = r25_raw >= DIV_BLINK;

    always_comb
    begin
        r25_next  = r25_hi ? 5'(r25_raw - DIV_BLINK) : 5'(r25_raw);
        q25_next  = e25_reg[1:0] + 2'(r25_hi);
        r180_next = (r180_raw >= DIV_RIPPLE) ? 8'(r180_raw - DIV_RIPPLE) : 8'(r180_raw);
        r300_fix  = (r300_raw >= DIV_CYCLE) ? (r300_raw - DIV_CYCLE) : r300_raw;
        // first of the six steps of EFF_CYCLE is dark
        dark_next = r300_fix < CYCLE_STEP;
    end

    // t mod 100 = 25 * ((t / 25) mod 4) + t mod 25
    assign r100_next = 7'(q25_reg) * BLINK_STEP + 7'(r25_reg);

    always_comb
    begin
        phase_next.tri_ripple = TRI_RIPPLE[r180b_reg];
        phase_next.tri_pulse  = TRI_PULSE[r100_reg];
        phase_next.blink_odd  = odd_reg;
        phase_next.cycle_dark = dark2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= in_valid;
            for (int i = 1; i < 4; i++)
            begin
                if (rdy[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            time_reg <= in_time;
            e25_reg  <= mul25[47:26];
            e180_reg <= mul180[47:26];
            e300_reg <= mul300[47:26];
        end
        if (rdy[1])
        begin
            r25_reg  <= r25_next;
            q25_reg  <= q25_next;
            r180_reg <= r180_next;
            dark_reg <= dark_next;
        end
        if (rdy[2])
        begin
            r100_reg  <= r100_next;
            r180b_reg <= r180_reg;
            odd_reg   <= q25_reg[0];
            dark2_reg <= dark_reg;
        end
        if (rdy[3])
            phase_reg <= phase_next;
    end

endmodule

// ===== design/led_efr_level.sv =====
// Effect level, brightness scaling and PWM duty mapping, five stages.
`timescale 1ns / 1ps

module led_efr_level
    import led_efr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  phase_t             in_phase,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [LEVEL_W-1:0] light_level,
    output logic [PWM_W-1:0]   pwm_duty
);

    logic [4:0] vld_reg;
    logic [5:0] rdy;

    logic [15:0]        luma_sum;
    logic [LEVEL_W-1:0] base;

    logic [15:0]        pprod_reg, pprod_next;
    logic [LEVEL_W-1:0] lvla_reg, lvla_next;
    logic               pulse_reg;
    logic [LEVEL_W-1:0] lvl_reg, lvl_next;
    logic [15:0]        bprod_reg, bprod_next;
    logic [LEVEL_W-1:0] light_reg, light_next;
    logic [LEVEL_W-1:0] lightb_reg;
    logic [PWM_W-1:0]   duty_reg, duty_next;
    logic [DUTY_BITS-1:0] duty_lin;
    logic [DUTY_BITS:0]   duty_word;

    // exact x / 255 for x up to 255 * 255
    function automatic logic [LEVEL_W-1:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = 17'(x) + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    always_comb
    begin
        rdy[5] = out_ready;
        for (int i = 4; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign in_ready    = rdy[0];
    assign out_valid   = vld_reg[4];
    assign light_level = lightb_reg;
    assign pwm_duty    = duty_reg;

    // the user must keep config static while items are in flight; the block leaves it unchecked
    assign luma_sum = 16'(16'd77 * cfg.red_level) + 16'(16'd150 * cfg.green_level)
                    + 16'(16'd29 * cfg.blue_level);
    assign base     = luma_sum[15:8];

    assign pprod_next = 16'(base) * 16'(in_phase.tri_pulse);

    always_comb
    begin
        case (cfg.effect_mode)
            EFF_OFF:    lvla_next = '0;
            EFF_SOLID:  lvla_next = base;
            EFF_RIPPLE: lvla_next = in_phase.tri_ripple;
            EFF_BLINK:  lvla_next = in_phase.blink_odd ? '0 : base;
            EFF_CYCLE:  lvla_next = in_phase.cycle_dark ? '0 : base;
            default:    lvla_next = '0;
        endcase
    end

    assign lvl_next   = pulse_reg ? div255(pprod_reg) : lvla_reg;
    assign bprod_next = 16'(lvl_reg) * 16'(cfg.brightness);
    assign light_next = div255(bprod_reg);

    assign duty_lin = DUTY_TAB[light_reg];

    always_comb
    begin
        if (cfg.active_low)
            duty_word = (light_reg == '0) ? DUTY_FULL : {1'b0, DUTY_TOP - duty_lin};
        else
            duty_word = (light_reg == LEVEL_W'(LEVEL_MAX)) ? DUTY_FULL : {1'b0, duty_lin};
        duty_next = PWM_W'(duty_word);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= in_valid;
            for (int i = 1; i < 5; i++)
            begin
                if (rdy[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            pprod_reg <= pprod_next;
            lvla_reg  <= lvla_next;
            pulse_reg <= (cfg.effect_mode == EFF_PULSE);
        end
        if (rdy[1])
            lvl_reg <= lvl_next;
        if (rdy[2])
            bprod_reg <= bprod_next;
        if (rdy[3])
            light_reg <= light_next;
        if (rdy[4])
        begin
            lightb_reg <= light_reg;
            duty_reg   <= duty_next;
        end
    end

endmodule

// ===== design/led_effect_frame_renderer_core.sv =====
// Top level of the LED effect frame renderer: config registers and the pipeline.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid / s_tready  s_tdata[31:0] frame_tick
//  m_*       out  m_tvalid / m_tready  m_tdata[7:0] light_level, [16:8] pwm_duty
//  cfg_*     in   cfg_valid / cfg_ready cfg_index register, cfg_data value
//
//  One item per cycle sustained while m_tready stays high; the delay from accept to
//  m_tvalid is set by the stage count of the divide-by-constant and scaling chain.
//  Every stage holds its item while the next one is full and stalled; empty stages fill up,
//  so s_tready stays high whenever the output side takes or has room.
//  Reset clears all valid bits and loads the config registers to their defaults.
//  cfg_ready is always high; an index beyond the register list is ignored.
`timescale 1ns / 1ps

module led_effect_frame_renderer_core
    import led_efr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [31:0] frame_tick
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [7:0] light_level, [16:8] pwm_duty, zero pad
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;

    logic              tick_valid, tick_ready;
    logic [TIME_W-1:0] tick_time;
    logic              ph_valid, ph_ready;
    phase_t            ph_data;
    logic [LEVEL_W-1:0] light;
    logic [PWM_W-1:0]   duty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.effect_mode   <= EFF_SOLID;
            cfg_reg.red_level     <= 8'd0;
            cfg_reg.green_level   <= 8'd0;
            cfg_reg.blue_level    <= 8'd16;
            cfg_reg.brightness    <= 8'd255;
            cfg_reg.speed_percent <= 10'd100;
            cfg_reg.active_low    <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_EFFECT_MODE: cfg_reg.effect_mode   <= cfg_data[2:0];
                REG_RED:         cfg_reg.red_level     <= cfg_data[7:0];
                REG_GREEN:       cfg_reg.green_level   <= cfg_data[7:0];
                REG_BLUE:        cfg_reg.blue_level    <= cfg_data[7:0];
                REG_BRIGHTNESS:  cfg_reg.brightness    <= cfg_data[7:0];
                REG_SPEED:       cfg_reg.speed_percent <= cfg_data[SPEED_W-1:0];
                REG_ACTIVE_LOW:  cfg_reg.active_low    <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    led_efr_tick u_tick (
        .clk           (clk),
        .rst_n         (rst_n),
        .speed_percent (cfg_reg.speed_percent),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_tick       (s_tdata),
        .out_valid     (tick_valid),
        .out_ready     (tick_ready),
        .out_time      (tick_time)
    );

    led_efr_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tick_valid),
        .in_ready  (tick_ready),
        .in_time   (tick_time),
        .out_valid (ph_valid),
        .out_ready (ph_ready),
        .out_phase (ph_data)
    );

    led_efr_level u_level (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (ph_valid),
        .in_ready    (ph_ready),
        .in_phase    (ph_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .light_level (light),
        .pwm_duty    (duty)
    );

    assign m_tdata = {7'd0, duty, light};

endmodule

// ===== design/led_efr_checker.sv =====
// Port-level checks of the LED effect frame renderer, bound to the top level.
`timescale 1ns / 1ps

module led_efr_checker
    import led_efr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [31:0]           s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [23:0]           m_tdata,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [2:0]            cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [PWM_W-1:0] FULL_PWM = PWM_W'(DUTY_FULL);

    // a stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

    // an empty or draining output stage lets the whole pipe move
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tready || !m_tvalid) |-> s_tready)
    else $error("input stalled while output side has room");

    // dark and full levels map to a sentinel or an edge duty
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[7:0] == 8'd0 || m_tdata[7:0] == 8'd255)
        |-> (m_tdata[16:8] == FULL_PWM || m_tdata[16:8] == 9'd0))
    else $error("duty word does not match a dark or full level");

    // no result during reset
    assert property (@(posedge clk) !rst_n |-> !m_tvalid)
    else $error("result valid during reset");

endmodule

bind led_effect_frame_renderer_core led_efr_checker u_checker (.*);

// ===== test/led_efr_frame_checker.sv =====
`timescale 1ns / 1ps
// Frame checker: predicts light level and PWM duty for each accepted tick and compares results.

module led_efr_frame_checker
    import led_efr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [31:0] frame_tick
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [23:0]           m_tdata,   // [7:0] light_level, [16:8] pwm_duty, zero pad
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    frames_in_flight
);

    localparam int BLINK_SPAN  = 25;
    localparam int CYCLE_SPAN  = 50;
    localparam int CYCLE_STEPS = 6;

    typedef struct packed {
        logic [PWM_W-1:0]   duty;
        logic [LEVEL_W-1:0] level;
    } frame_out_t;

    cfg_t       shadow;
    frame_out_t expected_frames[$];
    int         errors = 0;

    assign mismatches = errors;

    // 0..255..0 over one period, sampled at effect time t
    function automatic int unsigned triangle(int unsigned t, int unsigned period);
        int unsigned ph;
        int unsigned half;
        ph   = t % period;
        half = period / 2;
        if (ph < half)
            return ph * 255 / half;
        return (period - ph) * 255 / half;
    endfunction

    function automatic frame_out_t render_frame(logic [TICK_W-1:0] tick);
        logic [31:0] wrapped;
        int unsigned t;
        int unsigned luma;
        int unsigned lvl;
        int unsigned full;
        int unsigned top;
        int unsigned scaled;
        int unsigned duty;
        frame_out_t  r;
        // product wraps at 32 bits before the divide
        wrapped = tick * 32'(shadow.speed_percent);
        t       = wrapped / 100;
        luma    = (77 * shadow.red_level + 150 * shadow.green_level
                   + 29 * shadow.blue_level) >> 8;
        case (shadow.effect_mode)
            EFF_SOLID:  lvl = luma;
            EFF_RIPPLE: lvl = triangle(t, RIPPLE_PERIOD);
            EFF_PULSE:  lvl = luma * triangle(t, PULSE_PERIOD) / 255;
            EFF_BLINK:  lvl = ((t / BLINK_SPAN) % 2) ? 0 : luma;
            EFF_CYCLE:  lvl = ((t / CYCLE_SPAN) % CYCLE_STEPS == 0) ? 0 : luma;
            default:    lvl = 0;
        endcase
        lvl    = (lvl * shadow.brightness / 255) & 8'hFF;
        full   = 1 << DUTY_BITS;
        top    = full - 1;
        scaled = lvl * top / 255;
        if (shadow.active_low)
            duty = (lvl == 0) ? full : top - scaled;
        else
            duty = (lvl == 255) ? full : scaled;
        r.level = lvl[LEVEL_W-1:0];
        r.duty  = duty[PWM_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_out_t want;
        if (!rst_n)
        begin
            shadow.effect_mode   <= EFF_SOLID;
            shadow.red_level     <= 8'd0;
            shadow.green_level   <= 8'd0;
            shadow.blue_level    <= 8'd16;
            shadow.brightness    <= 8'd255;
            shadow.speed_percent <= 10'd100;
            shadow.active_low    <= 1'b1;
            frames_in_flight     <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_EFFECT_MODE: shadow.effect_mode   <= cfg_data[2:0];
                    REG_RED:         shadow.red_level     <= cfg_data[LEVEL_W-1:0];
                    REG_GREEN:       shadow.green_level   <= cfg_data[LEVEL_W-1:0];
                    REG_BLUE:        shadow.blue_level    <= cfg_data[LEVEL_W-1:0];
                    REG_BRIGHTNESS:  shadow.brightness    <= cfg_data[LEVEL_W-1:0];
                    REG_SPEED:       shadow.speed_percent <= cfg_data[SPEED_W-1:0];
                    REG_ACTIVE_LOW:  shadow.active_low    <= cfg_data[0];
                    default:         ;  // index past the register list is dropped
                endcase
            end
            if (s_tvalid && s_tready)
                expected_frames.push_back(render_frame(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (expected_frames.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item, expected none, actual level %0d duty %0d",
                             $time, m_tdata[7:0], m_tdata[16:8]);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (m_tdata[7:0] !== want.level)
                    begin
                        errors++;
                        $display("%0t: light_level mismatch, expected %0d, actual %0d",
                                 $time, want.level, m_tdata[7:0]);
                    end
                    if (m_tdata[16:8] !== want.duty)
                    begin
                        errors++;
                        $display("%0t: pwm_duty mismatch, expected %0d, actual %0d",
                                 $time, want.duty, m_tdata[16:8]);
                    end
                end
            end
            frames_in_flight <= expected_frames.size();
        end
    end

endmodule

// ===== test/led_effect_frame_renderer_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top: drives frame ticks and register writes into the renderer and gives the verdict.

module led_effect_frame_renderer_core_tb;
    import led_efr_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 30;
    localparam int SEGMENTS      = 8;
    localparam int SEGMENT_ITEMS = 40;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [2:0]            index;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic                  clk       = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [2:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int                    mismatches;
    int                    frames_in_flight;
    int                    tx_idle_pct = 0;
    int                    rx_idle_pct = 0;
    int                    cycle_count = 0;
    bit                    hold_active = 1'b0;
    event                  start_hold;
    logic [SPEED_W-1:0]    cur_speed   = 10'd100;
    reg_write_t            reg_writes[$];

    led_effect_frame_renderer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    led_efr_frame_checker frame_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .frames_in_flight (frames_in_flight)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= !hold_active && ($urandom_range(99) >= rx_idle_pct);

    // long receiver stall so the pipeline fills and backs up into s_tready
    initial
    begin
        forever
        begin
            @(start_hold);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active = 1'b0;
        end
    end

    task automatic send_frame(logic [31:0] tick);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tick;
        do @(posedge clk); while (!s_tready);
    endtask

    // stop offering and wait for every predicted frame to come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (frames_in_flight != 0);
    endtask

    task automatic set_reg(logic [2:0] index, logic [CFG_DATA_W-1:0] data);
        reg_write_t w;
        w.index = index;
        w.data  = data;
        reg_writes.push_back(w);
    endtask

    task automatic apply_regs();
        reg_write_t w;
        while (reg_writes.size() != 0)
        begin
            w = reg_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.index;
            cfg_data  <= w.data;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // upper data bits beyond each register's width carry noise
    task automatic randomize_regs();
        logic [2:0]         effect;
        logic [SPEED_W-1:0] speed;
        effect = 3'($urandom);
        case ($urandom_range(7))
            0:       speed = 10'd0;
            1:       speed = 10'd10;
            2:       speed = 10'd1000;
            3:       speed = 10'd1023;
            4, 5:    speed = 10'($urandom_range(1000, 10));
            default: speed = 10'($urandom_range(200, 10));
        endcase
        cur_speed = speed;
        set_reg(REG_EFFECT_MODE, {7'($urandom), effect});
        set_reg(REG_RED,         {2'($urandom), pick_level()});
        set_reg(REG_GREEN,       {2'($urandom), pick_level()});
        set_reg(REG_BLUE,        {2'($urandom), pick_level()});
        set_reg(REG_BRIGHTNESS,  {2'($urandom), pick_level()});
        set_reg(REG_SPEED,       speed);
        set_reg(REG_ACTIVE_LOW,  {9'($urandom), 1'($urandom)});
        if ($urandom_range(3) == 0)
            set_reg(REG_UNUSED, 10'($urandom));
    endtask

    function automatic logic [31:0] random_tick();
        case ($urandom_range(4))
            0, 1:    return $urandom;
            2:       return $urandom_range(3000);
            3:
            begin
                // around the point where tick * speed wraps
                if (cur_speed == 0)
                    return $urandom;
                return 32'hFFFF_FFFF / cur_speed + $urandom_range(8) - 4;
            end
            default: return 32'hFFFF_FFFF - $urandom_range(500);
        endcase
    endfunction

    initial
    begin
        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults
        send_frame(32'd0);
        send_frame(32'hFFFF_FFFF);
        drain();

        // full white, active high: every effect code including the unused ones
        set_reg(REG_RED,        10'd255);
        set_reg(REG_GREEN,      10'd255);
        set_reg(REG_BLUE,       10'd255);
        set_reg(REG_BRIGHTNESS, 10'd255);
        set_reg(REG_SPEED,      10'd100);
        set_reg(REG_ACTIVE_LOW, 10'd0);
        for (int e = 0; e < 8; e++)
        begin
            set_reg(REG_EFFECT_MODE, CFG_DATA_W'(e));
            apply_regs();
            send_frame(32'(e * 45 + 25));
            send_frame(32'hFFFF_FFFF - 32'(e * 7));
            drain();
        end

        // dark level, active low, plus a write past the register list
        set_reg(REG_ACTIVE_LOW,  10'd1);
        set_reg(REG_BRIGHTNESS,  10'd0);
        set_reg(REG_EFFECT_MODE, CFG_DATA_W'(EFF_SOLID));
        set_reg(REG_UNUSED,      10'h3FF);
        apply_regs();
        send_frame(32'd5);
        drain();

        // zero speed freezes time
        set_reg(REG_BRIGHTNESS,  10'd255);
        set_reg(REG_EFFECT_MODE, CFG_DATA_W'(EFF_RIPPLE));
        set_reg(REG_SPEED,       10'd0);
        apply_regs();
        send_frame(32'hFFFF_FFFF);
        drain();

        // largest speed with a wrapping product
        set_reg(REG_SPEED, 10'd1023);
        apply_regs();
        cur_speed = 10'd1023;
        send_frame(32'hFFFF_FFFF);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 28;
                    rx_idle_pct = 69;
                end
                1:
                begin
                    tx_idle_pct = 69;
                    rx_idle_pct = 28;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                drain();
                randomize_regs();
                apply_regs();
                if (phase == 2 && seg == 0)
                    -> start_hold;
                repeat (SEGMENT_ITEMS) send_frame(random_tick());
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && frames_in_flight == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
